>>> rtl/tswb_pkg.sv
// Shared types and constants of the timestamped sample window buffer.
`default_nettype none

package tswb_pkg;

  // Fixed field widths
  localparam int TIME_W    = 64;
  localparam int DATA_W    = 64;
  localparam int FUNC_W    = 2;
  localparam int S_TDATA_W = 4 * 64;
  localparam int M_TDATA_W = 2 * 64;

  // Operation codes carried on s_tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_SINCE = 2'd1,
    FUNC_RANGE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Query sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LO_RD,
    ST_LO_CMP,
    ST_HI_RD,
    ST_HI_CMP,
    ST_EM_SETUP,
    ST_EM_RD,
    ST_EM_WAIT,
    ST_EMPTY
  } state_t;

endpackage

`default_nettype wire

>>> rtl/tswb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tswb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/timestamped_sample_window_buffer_top.sv
// Top level of the timestamped sample window buffer: ring storage and query sequencer.
//
// A ring of DEPTH timestamped samples held in two RAMs (time and payload) with one
// read port each. A push (s_tuser = 0) overwrites the oldest sample once the ring
// is full. A since query (1) or range query (2) is accepted, then runs a binary
// search over the held samples, each probe a RAM read followed by a compare; a
// range query does a lower and an upper search. After a setup state the matching
// samples are streamed oldest first, each result transfer a RAM read followed by
// an output register load, held by any output stall. A since query that matches
// nothing, or a range query with no sample at or after from_time, emits one
// transfer with m_tuser set; any other range query that matches nothing emits the
// first later sample. A reversed range emits nothing. s_tready is high only between
// items. Storage is not cleared at reset; only written entries are ever read.
`default_nettype none

module timestamped_sample_window_buffer_top #(
  parameter int DEPTH        = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // sink: tuser = func; tdata = sample_time, sample_data, from_time, to_time
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [tswb_pkg::S_TDATA_W-1:0]   s_tdata,
  input  wire logic [tswb_pkg::FUNC_W-1:0]      s_tuser,
  // source: tdata = found_time, found_data; tuser = is_empty; tlast = is_last
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [tswb_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                                  m_tuser,
  output logic                                  m_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT   = CW'(1);

  // Ring position to RAM slot: (oldest + pos) mod DEPTH, sum stays below 2*DEPTH
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] oldest,
                                            input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = (CW + 1)'(oldest) + (CW + 1)'(pos);
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[AW-1:0];
  endfunction

  tswb_pkg::state_t state, state_next;

  logic [tswb_pkg::FUNC_W-1:0] func_q;
  logic signed [tswb_pkg::TIME_W-1:0] from_q, to_q;
  logic [CW-1:0] fill_count;
  logic [AW-1:0] oldest_slot;
  logic [CW-1:0] lo_pos, hi_pos, srch_cnt, emit_pos, emit_left;

  logic [CW-1:0] half, probe_pos, rd_pos, emit_cnt;
  logic [AW-1:0] rd_slot, wr_slot;
  logic          rd_en, wr_en, s_acc, out_free, out_load;
  logic          is_range, upper_phase;

  logic signed [tswb_pkg::TIME_W-1:0] in_time, in_from, in_to;
  logic [PAYLOAD_BITS-1:0]            in_data;
  logic [tswb_pkg::TIME_W-1:0]        time_rd;
  logic [PAYLOAD_BITS-1:0]            data_rd;

  // Input field unpacking
  assign in_time = s_tdata[63:0];
  assign in_data = s_tdata[64 +: PAYLOAD_BITS];
  assign in_from = s_tdata[191:128];
  assign in_to   = s_tdata[255:192];

  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign is_range = (func_q == tswb_pkg::FUNC_RANGE);

  // Search probe and read address
  assign upper_phase = (state == tswb_pkg::ST_HI_RD) || (state == tswb_pkg::ST_HI_CMP);
  assign half        = srch_cnt >> 1;
  assign probe_pos   = (upper_phase ? hi_pos : lo_pos) + half;
  assign rd_pos      = (state == tswb_pkg::ST_EM_RD) ? emit_pos : probe_pos;
  assign rd_slot     = slot_of(oldest_slot, rd_pos);

  // Push slot: append while filling, overwrite oldest once full
  assign wr_slot = (fill_count == DEPTH_CNT) ? oldest_slot : slot_of(oldest_slot, fill_count);
  assign wr_en   = s_acc && (s_tuser == tswb_pkg::FUNC_PUSH);

  // Number of samples to emit, from the search results
  always_comb begin
    if (!is_range) begin
      emit_cnt = fill_count - lo_pos;
    end else if (hi_pos <= lo_pos) begin
      emit_cnt = (lo_pos < fill_count) ? ONE_CNT : '0;
    end else begin
      emit_cnt = hi_pos - lo_pos;
    end
  end

  tswb_ram #(.WIDTH(tswb_pkg::TIME_W), .DEPTH(DEPTH)) u_time_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_slot),
    .wr_data (in_time),
    .rd_en   (rd_en),
    .rd_addr (rd_slot),
    .rd_data (time_rd)
  );

  tswb_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(DEPTH)) u_data_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_slot),
    .wr_data (in_data),
    .rd_en   (rd_en),
    .rd_addr (rd_slot),
    .rd_data (data_rd)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tswb_pkg::ST_IDLE: begin
        if (s_acc) begin
          if (s_tuser == tswb_pkg::FUNC_SINCE) begin
            state_next = tswb_pkg::ST_LO_RD;
          end else if (s_tuser == tswb_pkg::FUNC_RANGE && !(in_to < in_from)) begin
            state_next = tswb_pkg::ST_LO_RD;
          end
        end
      end
      tswb_pkg::ST_LO_RD: begin
        if (srch_cnt == '0) begin
          state_next = is_range ? tswb_pkg::ST_HI_RD : tswb_pkg::ST_EM_SETUP;
        end else begin
          state_next = tswb_pkg::ST_LO_CMP;
        end
      end
      tswb_pkg::ST_LO_CMP: state_next = tswb_pkg::ST_LO_RD;
      tswb_pkg::ST_HI_RD: begin
        state_next = (srch_cnt == '0) ? tswb_pkg::ST_EM_SETUP : tswb_pkg::ST_HI_CMP;
      end
      tswb_pkg::ST_HI_CMP: state_next = tswb_pkg::ST_HI_RD;
      tswb_pkg::ST_EM_SETUP: begin
        state_next = (emit_cnt == '0) ? tswb_pkg::ST_EMPTY : tswb_pkg::ST_EM_RD;
      end
      tswb_pkg::ST_EM_RD: state_next = tswb_pkg::ST_EM_WAIT;
      tswb_pkg::ST_EM_WAIT: begin
        if (out_free) begin
          state_next = (emit_left == ONE_CNT) ? tswb_pkg::ST_IDLE : tswb_pkg::ST_EM_RD;
        end
      end
      tswb_pkg::ST_EMPTY: begin
        if (out_free) begin
          state_next = tswb_pkg::ST_IDLE;
        end
      end
      default: state_next = tswb_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    case (state)
      tswb_pkg::ST_IDLE:    s_tready = 1'b1;
      tswb_pkg::ST_LO_RD,
      tswb_pkg::ST_HI_RD:   rd_en = (srch_cnt != '0);
      tswb_pkg::ST_EM_RD:   rd_en = 1'b1;
      tswb_pkg::ST_EM_WAIT,
      tswb_pkg::ST_EMPTY:   out_load = out_free;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tswb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      oldest_slot <= '0;
    end else if (wr_en) begin
      if (fill_count != DEPTH_CNT) begin
        fill_count <= fill_count + ONE_CNT;
      end else begin
        oldest_slot <= slot_of(oldest_slot, ONE_CNT);
      end
    end
  end

  // Search and emit counters
  always_ff @(posedge clk) begin
    if (rst) begin
      func_q    <= tswb_pkg::FUNC_NONE;
      lo_pos    <= '0;
      hi_pos    <= '0;
      srch_cnt  <= '0;
      emit_pos  <= '0;
      emit_left <= '0;
    end else begin
      case (state)
        tswb_pkg::ST_IDLE: begin
          if (s_acc && s_tuser != tswb_pkg::FUNC_PUSH) begin
            func_q   <= s_tuser;
            lo_pos   <= '0;
            srch_cnt <= fill_count;
          end
        end
        tswb_pkg::ST_LO_RD: begin
          if (srch_cnt == '0) begin
            hi_pos   <= '0;
            srch_cnt <= fill_count;
          end
        end
        tswb_pkg::ST_LO_CMP: begin
          if ($signed(time_rd) < from_q) begin
            lo_pos   <= probe_pos + ONE_CNT;
            srch_cnt <= srch_cnt - half - ONE_CNT;
          end else begin
            srch_cnt <= half;
          end
        end
        tswb_pkg::ST_HI_CMP: begin
          if (!(to_q < $signed(time_rd))) begin
            hi_pos   <= probe_pos + ONE_CNT;
            srch_cnt <= srch_cnt - half - ONE_CNT;
          end else begin
            srch_cnt <= half;
          end
        end
        tswb_pkg::ST_EM_SETUP: begin
          emit_pos  <= lo_pos;
          emit_left <= emit_cnt;
        end
        tswb_pkg::ST_EM_WAIT: begin
          if (out_free) begin
            emit_pos  <= emit_pos + ONE_CNT;
            emit_left <= emit_left - ONE_CNT;
          end
        end
        default: begin
          emit_left <= emit_left;
        end
      endcase
    end
  end

  // Query bounds
  always_ff @(posedge clk) begin
    if (state == tswb_pkg::ST_IDLE && s_acc) begin
      from_q <= in_from;
      to_q   <= in_to;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == tswb_pkg::ST_EMPTY) begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
        m_tlast <= 1'b1;
      end else begin
        m_tdata <= {tswb_pkg::DATA_W'(data_rd), time_rd};
        m_tuser <= 1'b0;
        m_tlast <= (emit_left == ONE_CNT);
      end
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= DEPTH_CNT)
    else $error("fill count above ring depth");

  a_oldest_full: assert property (@(posedge clk) disable iff (rst)
    (fill_count != DEPTH_CNT) |-> (oldest_slot == '0))
    else $error("oldest slot moved before ring filled");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while held");

  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    (state == tswb_pkg::ST_LO_CMP) |->
      (((CW + 1)'(lo_pos) + (CW + 1)'(srch_cnt)) <= (CW + 1)'(fill_count)))
    else $error("search window past held samples");

  a_emit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == tswb_pkg::ST_EM_WAIT) |-> (emit_left != '0))
    else $error("emit with no samples left");

endmodule

`default_nettype wire
